[hdl/samrd_pkg.sv]
package samrd_pkg;

    typedef enum logic [2:0] {
        ACT_ADD = 3'd0,
        ACT_SUB = 3'd1,
        ACT_MUL = 3'd2,
        ACT_DIV = 3'd3,
        ACT_REM = 3'd4
    } t_action;

    typedef struct packed {
        logic [2:0]  action;
        logic [31:0] operand_a;
        logic [31:0] operand_b;
    } t_in_beat;

    typedef struct packed {
        logic [31:0] result;
        logic        divide_by_zero;
    } t_out_beat;

endpackage

[hdl/samrd_cell.sv]
module samrd_cell #(
    parameter int WIDTH = 32,
    parameter int STEP  = 0
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_adv,
    input  logic             i_vld,
    input  logic [2:0]       i_act,
    input  logic [WIDTH-1:0] i_a,
    input  logic [WIDTH-1:0] i_b,
    input  logic [WIDTH-1:0] i_acc,
    input  logic [WIDTH-1:0] i_rem,
    output logic             o_vld,
    output logic [2:0]       o_act,
    output logic [WIDTH-1:0] o_a,
    output logic [WIDTH-1:0] o_b,
    output logic [WIDTH-1:0] o_acc,
    output logic [WIDTH-1:0] o_rem
);

    localparam int POS = WIDTH - 1 - STEP;

    logic             r_vld;
    logic [2:0]       r_act;
    logic [WIDTH-1:0] r_a, r_b, r_acc, r_rem;
    logic [WIDTH-1:0] n_acc, n_rem, w_sh, w_diff;
    logic             w_carry, w_ge;
    logic             w_div;

    // multiply: add a shifted copy; divide: one restoring step (acc holds quotient)
    assign w_div   = (i_act == samrd_pkg::ACT_DIV) || (i_act == samrd_pkg::ACT_REM);
    assign w_carry = i_rem[WIDTH-1];
    assign w_sh    = {i_rem[WIDTH-2:0], i_a[POS]};
    assign w_ge    = w_carry || (w_sh >= i_b);
    assign w_diff  = w_sh - i_b;

    always_comb begin
        n_acc = i_acc;
        n_rem = i_rem;
        if (w_div) begin
            n_rem = w_ge ? w_diff : w_sh;
            n_acc = {i_acc[WIDTH-2:0], w_ge};
        end else if (i_act == samrd_pkg::ACT_MUL) begin
            if (i_b[STEP]) begin
                n_acc = i_acc + (i_a << STEP);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (i_adv) begin
            r_vld <= i_vld;
        end
        if (i_adv) begin
            r_act <= i_act;
            r_a   <= i_a;
            r_b   <= i_b;
            r_acc <= n_acc;
            r_rem <= n_rem;
        end
    end

    assign o_vld = r_vld;
    assign o_act = r_act;
    assign o_a   = r_a;
    assign o_b   = r_b;
    assign o_acc = r_acc;
    assign o_rem = r_rem;

endmodule

[hdl/shift_add_mul_restoring_div_alu.sv]
// unsigned arithmetic unit: add, subtract, multiply, divide, remainder
// input channel: i_in_valid / o_in_stall, payload i_in (action, operand_a, operand_b)
// output channel: o_out_valid / i_out_stall, payload o_out (result, divide_by_zero)
// one result beat for each input beat, in order
// the beat passes a row of WIDTH cells, one multiply bit or one quotient bit each,
// then an output register
// throughput one beat per cycle unless the receiver stalls; the whole row moves together
// add and subtract are computed on entry and carried through the row
// zero divisor gives result 0 with divide_by_zero set; codes 5 to 7 give 0
// reset clears all valid bits; payload registers are not reset
// when the receiver stalls with a full output register the row freezes and
// o_in_stall rises; bubbles in the row move along with it and are not squeezed out
module shift_add_mul_restoring_div_alu #(
    parameter int WIDTH = 32
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  samrd_pkg::t_in_beat  i_in,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output samrd_pkg::t_out_beat o_out
);

    logic             c_vld [WIDTH+1];
    logic [2:0]       c_act [WIDTH+1];
    logic [WIDTH-1:0] c_a   [WIDTH+1];
    logic [WIDTH-1:0] c_b   [WIDTH+1];
    logic [WIDTH-1:0] c_acc [WIDTH+1];
    logic [WIDTH-1:0] c_rem [WIDTH+1];
    logic             w_adv;
    logic [WIDTH-1:0] w_a, w_b;
    logic             r_out_vld;
    samrd_pkg::t_out_beat r_out, n_out;

    assign w_adv = !r_out_vld || !i_out_stall;
    assign o_in_stall = !w_adv;

    assign w_a = WIDTH'(i_in.operand_a);
    assign w_b = WIDTH'(i_in.operand_b);

    assign c_vld[0] = i_in_valid;
    assign c_act[0] = i_in.action;
    assign c_a[0]   = w_a;
    assign c_b[0]   = w_b;
    assign c_rem[0] = '0;
    always_comb begin
        unique case (i_in.action)
            samrd_pkg::ACT_ADD: c_acc[0] = w_a + w_b;
            samrd_pkg::ACT_SUB: c_acc[0] = w_a - w_b;
            default:            c_acc[0] = '0;
        endcase
    end

    for (genvar g = 0; g < WIDTH; g++) begin : g_row
        samrd_cell #(.WIDTH(WIDTH), .STEP(g)) u_cell (
            .i_clk  (i_clk),
            .i_rst_n(i_rst_n),
            .i_adv  (w_adv),
            .i_vld  (c_vld[g]),
            .i_act  (c_act[g]),
            .i_a    (c_a[g]),
            .i_b    (c_b[g]),
            .i_acc  (c_acc[g]),
            .i_rem  (c_rem[g]),
            .o_vld  (c_vld[g+1]),
            .o_act  (c_act[g+1]),
            .o_a    (c_a[g+1]),
            .o_b    (c_b[g+1]),
            .o_acc  (c_acc[g+1]),
            .o_rem  (c_rem[g+1])
        );
    end

    always_comb begin
        n_out = '0;
        unique case (c_act[WIDTH])
            samrd_pkg::ACT_ADD, samrd_pkg::ACT_SUB, samrd_pkg::ACT_MUL: begin
                n_out.result = 32'(c_acc[WIDTH]);
            end
            samrd_pkg::ACT_DIV, samrd_pkg::ACT_REM: begin
                if (c_b[WIDTH] == '0) begin
                    n_out.divide_by_zero = 1'b1;
                end else if (c_act[WIDTH] == samrd_pkg::ACT_DIV) begin
                    n_out.result = 32'(c_acc[WIDTH]);
                end else begin
                    n_out.result = 32'(c_rem[WIDTH]);
                end
            end
            default: n_out = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (w_adv) begin
            r_out_vld <= c_vld[WIDTH];
        end
        if (w_adv) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid = r_out_vld;
    assign o_out       = r_out;

    a_stall_only_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> (r_out_vld && i_out_stall))
        else $error("input stalled without a blocked output beat");
    a_dz_only_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out.divide_by_zero) |-> (o_out.result == '0))
        else $error("divide by zero with nonzero result");
    a_row_feeds_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_adv && c_vld[WIDTH]) |=> o_out_valid)
        else $error("last cell beat lost");

endmodule
